// ----- hw/rtl/local_history_branch_predictor_unit_defines.svh -----
// Assertion macros for the branch predictor RTL.
// The clock is clk and the reset is rst_n, active low, in every user.
`ifndef LOCAL_HISTORY_BRANCH_PREDICTOR_UNIT_DEFINES_SVH
`define LOCAL_HISTORY_BRANCH_PREDICTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// expr must never be true at a clock edge
`define LHBP_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("lhbp assertion failed");

// whenever ante holds, cons holds in the same cycle
`define LHBP_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lhbp assertion failed");

`else

`define LHBP_ASSERT_NEVER(lbl, expr)
`define LHBP_ASSERT_IMPLY(lbl, ante, cons)

`endif

`endif

// ----- hw/rtl/lhbp_pkg.sv -----
package lhbp_pkg;

  localparam int ENTRIES_MAX = 16;
  localparam int HIST_MAX    = 8;
  localparam int INDEX_BITS  = 16;

  localparam int ENT_W     = $clog2(ENTRIES_MAX);
  localparam int NCFG_W    = 5;
  localparam int HBCFG_W   = 4;
  localparam int CTR_DEPTH = ENTRIES_MAX << HIST_MAX;
  localparam int CTR_AW    = ENT_W + HIST_MAX;
  localparam int MISS_W    = 32;

  // modulo unit: remainder bits resolved per cycle
  localparam int STEP_BITS = 8;
  localparam int DIV_CYC   = INDEX_BITS / STEP_BITS;
  localparam int DIVC_W    = (DIV_CYC > 2) ? $clog2(DIV_CYC) : 1;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIST    = 8'd1;

  localparam logic [NCFG_W-1:0]  ENTRIES_RST = 5'd1;
  localparam logic [HBCFG_W-1:0] HIST_RST    = 4'd2;

  localparam logic [1:0] CTR_SN = 2'd0;
  localparam logic [1:0] CTR_WN = 2'd1;
  localparam logic [1:0] CTR_WT = 2'd2;
  localparam logic [1:0] CTR_ST = 2'd3;

  localparam int IN_W  = 24;
  localparam int OUT_W = 48;

  typedef struct packed {
    logic [ENT_W-1:0] entry;
    logic             taken;
  } qitem_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } bk_stat_t;

  // lowest bits first in the word: entry, history, prediction, miss flag, count
  typedef struct packed {
    logic [MISS_W-1:0]   miss_count;
    logic                mispredicted;
    logic                predicted_taken;
    logic [HIST_MAX-1:0] history_used;
    logic [ENT_W-1:0]    entry_index;
  } res_t;

  localparam int RES_W = $bits(res_t);

  function automatic logic [NCFG_W-1:0] eff_entries(input logic [NCFG_W-1:0] cfg);
    logic [NCFG_W-1:0] n;
    n = cfg;
    if (n == '0) n = NCFG_W'(1);
    if (n > NCFG_W'(ENTRIES_MAX)) n = NCFG_W'(ENTRIES_MAX);
    return n;
  endfunction

  function automatic logic [HBCFG_W-1:0] eff_hbits(input logic [HBCFG_W-1:0] cfg);
    logic [HBCFG_W-1:0] b;
    b = cfg;
    if (b == '0) b = HBCFG_W'(1);
    if (b > HBCFG_W'(HIST_MAX)) b = HBCFG_W'(HIST_MAX);
    return b;
  endfunction

  function automatic logic [HIST_MAX-1:0] hist_mask(input logic [HBCFG_W-1:0] hb);
    logic [HIST_MAX-1:0] m;
    for (int i = 0; i < HIST_MAX; i++) begin
      m[i] = (HBCFG_W'(i) < hb);
    end
    return m;
  endfunction

  // restoring remainder, one dividend bit per step, msb first
  function automatic logic [ENT_W-1:0] mod_steps(input logic [ENT_W-1:0] rem,
                                                 input logic [STEP_BITS-1:0] bits,
                                                 input logic [NCFG_W-1:0] n);
    logic [ENT_W:0] r;
    r = {1'b0, rem};
    for (int k = 0; k < STEP_BITS; k++) begin
      r = {r[ENT_W-1:0], bits[STEP_BITS-1-k]};
      if (r >= n) r = r - n;
    end
    return r[ENT_W-1:0];
  endfunction

  function automatic logic [1:0] ctr_update(input logic [1:0] ctr, input logic taken);
    logic [1:0] c;
    c = ctr;
    if (taken) begin
      if (c != CTR_ST) c = c + 2'd1;
    end else begin
      if (c != CTR_SN) c = c - 2'd1;
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/lhbp_ram.sv -----
module lhbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/lhbp_front.sv -----
module lhbp_front
  import lhbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  input  logic              hold,
  input  logic [NCFG_W-1:0] n_eff,
  output logic              q_push,
  output qitem_t            q_item,
  input  logic              q_full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_HOLD = 3'b100
  } fstate_t;

  fstate_t                 state_r, state_nxt;
  logic [ENT_W-1:0]        rem_r, rem_nxt;
  logic [INDEX_BITS-1:0]   shf_r, shf_nxt;
  logic [DIVC_W-1:0]       cnt_r, cnt_nxt;
  logic                    taken_r, taken_nxt;
  logic [INDEX_BITS-1:0]   in_idx;
  logic [ENT_W-1:0]        rem_c;

  assign in_idx    = in_tdata[INDEX_BITS-1:0];
  assign in_tready = (state_r == F_IDLE) && !hold;
  assign rem_c     = mod_steps(rem_r, shf_r[INDEX_BITS-1 -: STEP_BITS], n_eff);

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    shf_nxt   = shf_r;
    cnt_nxt   = cnt_r;
    taken_nxt = taken_r;
    q_push    = 1'b0;
    q_item    = '{entry: rem_r, taken: taken_r};
    case (state_r)
      F_IDLE: begin
        if (in_tvalid && in_tready) begin
          // top bits resolved in the accept cycle
          rem_nxt   = mod_steps('0, in_idx[INDEX_BITS-1 -: STEP_BITS], n_eff);
          shf_nxt   = in_idx << STEP_BITS;
          taken_nxt = in_tdata[INDEX_BITS];
          cnt_nxt   = DIVC_W'(1);
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        rem_nxt = rem_c;
        shf_nxt = shf_r << STEP_BITS;
        cnt_nxt = cnt_r + DIVC_W'(1);
        if (cnt_r == DIVC_W'(DIV_CYC - 1)) begin
          q_item = '{entry: rem_c, taken: taken_r};
          q_push = !q_full;
          state_nxt = q_full ? F_HOLD : F_IDLE;
        end
      end
      F_HOLD: begin
        q_push = !q_full;
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    rem_r   <= rem_nxt;
    shf_r   <= shf_nxt;
    taken_r <= taken_nxt;
  end

endmodule

// ----- hw/rtl/lhbp_queue.sv -----
module lhbp_queue
  import lhbp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  qitem_t push_item,
  output logic   full,
  input  logic   pop,
  output logic   valid,
  output qitem_t head
);

  qitem_t              slot_r [Q_DEPTH];
  logic [Q_AW-1:0]     wptr_r, wptr_nxt;
  logic [Q_AW-1:0]     rptr_r, rptr_nxt;
  logic [Q_AW:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + Q_AW'(1) : wptr_r;
    rptr_nxt = pop  ? rptr_r + Q_AW'(1) : rptr_r;
    cnt_nxt  = cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push) slot_r[wptr_r] <= push_item;
  end

endmodule

// ----- hw/rtl/lhbp_back.sv -----
module lhbp_back
  import lhbp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  qitem_t             q_head,
  output logic               q_pop,
  input  logic [HBCFG_W-1:0] hb_eff,
  output bk_stat_t           stat,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } bstate_t;

  bstate_t              state_r, state_nxt;
  logic [CTR_AW-1:0]    clr_r, clr_nxt;
  logic [ENT_W-1:0]     entry_r, entry_nxt;
  logic [HIST_MAX-1:0]  hist_r, hist_nxt;
  logic                 taken_r, taken_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_data_r, out_data_nxt;

  logic [HIST_MAX-1:0]  hist_regs_r [ENTRIES_MAX];
  logic [MISS_W-1:0]    miss_regs_r [ENTRIES_MAX];

  logic                 ram_we, ram_re;
  logic [CTR_AW-1:0]    ram_waddr, ram_raddr;
  logic [1:0]           ram_wdata, ram_rdata;

  logic                 commit;
  logic [HIST_MAX-1:0]  hist_lk;
  logic                 pred, miss;
  logic [MISS_W-1:0]    miss_old;
  logic [MISS_W-1:0]    miss_new_nxt;
  logic [HIST_MAX-1:0]  hist_new_nxt;

  lhbp_ram #(
    .WIDTH (2),
    .DEPTH (CTR_DEPTH)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign hist_lk  = hist_regs_r[q_head.entry] & hist_mask(hb_eff);
  assign pred     = ram_rdata[1];
  assign miss     = (pred != taken_r);
  assign miss_old = miss_regs_r[entry_r];
  assign miss_new_nxt = (miss && (miss_old != '1)) ? miss_old + MISS_W'(1) : miss_old;
  assign hist_new_nxt = {hist_regs_r[entry_r][HIST_MAX-2:0], taken_r};

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    entry_nxt     = entry_r;
    hist_nxt      = hist_r;
    taken_nxt     = taken_r;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = {entry_r, hist_r};
    ram_wdata     = ctr_update(ram_rdata, taken_r);
    ram_re        = 1'b0;
    ram_raddr     = {q_head.entry, hist_lk};
    commit        = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = CTR_SN;
        clr_nxt   = clr_r + CTR_AW'(1);
        if (clr_r == CTR_AW'(CTR_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          ram_re    = 1'b1;
          entry_nxt = q_head.entry;
          hist_nxt  = hist_lk;
          taken_nxt = q_head.taken;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        // counter read data holds until the output slot frees
        if (!out_valid_r || out_tready) begin
          commit       = 1'b1;
          ram_we       = 1'b1;
          out_data_nxt = '{miss_count:      miss_new_nxt,
                           mispredicted:    miss,
                           predicted_taken: pred,
                           history_used:    hist_r,
                           entry_index:     entry_r};
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = commit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ENTRIES_MAX; i++) begin
        hist_regs_r[i] <= '0;
        miss_regs_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        hist_regs_r[entry_r] <= hist_new_nxt;
        miss_regs_r[entry_r] <= miss_new_nxt;
      end
    end
    entry_r    <= entry_nxt;
    hist_r     <= hist_nxt;
    taken_r    <= taken_nxt;
    out_data_r <= out_data_nxt;
  end

  assign stat.clearing = (state_r == S_CLEAR);
  assign stat.busy     = (state_r == S_LOOK);
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = {{(OUT_W-RES_W){1'b0}}, out_data_r};

endmodule

// ----- hw/rtl/local_history_branch_predictor_unit.sv -----
// Channel | Handshake               | Word contents (lowest bit up)
// in_     | in_tvalid / in_tready   | branch_index[15:0], taken[16], zero pad
// out_    | out_tvalid / out_tready | entry_index[3:0], history_used[11:4],
//         |                         | predicted_taken[12], mispredicted[13],
//         |                         | miss_count[45:14], zero pad
// cfg_    | cfg_valid / cfg_ready   | cfg_index selects register, cfg_data
//
// The front takes no new branch until it has done the entry modulo (8 remainder
// bits a cycle); the back reads the counter RAM, then writes it back. A branch
// passes the front, the queue, the RAM read and the write-back before out_tvalid.
// After reset a pass zeroes all 4096 counter RAM entries; in_tready stays low.
// A 2-deep queue splits front and back; the output register lets the back
// fetch the next branch while a result waits.
`include "local_history_branch_predictor_unit_defines.svh"

module local_history_branch_predictor_unit
  import lhbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // branch_index[15:0], taken[16], pad[23:17]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,
  // entry_index[3:0], history_used[11:4], predicted_taken[12],
  // mispredicted[13], miss_count[45:14], pad[47:46]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [NCFG_W-1:0]  entries_r;
  logic [HBCFG_W-1:0] hbits_r;
  logic [NCFG_W-1:0]  n_eff;
  logic [HBCFG_W-1:0] hb_eff;

  logic     q_push, q_full, q_pop, q_valid;
  qitem_t   q_item, q_head;
  bk_stat_t bk_stat;
  logic [ENT_W-1:0] out_ent;

  // config word always taken; unknown indexes dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= ENTRIES_RST;
      hbits_r   <= HIST_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENTRIES: entries_r <= cfg_data[NCFG_W-1:0];
        REG_HIST:    hbits_r   <= cfg_data[HBCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero and oversize settings clamp to the legal range
  assign n_eff  = eff_entries(entries_r);
  assign hb_eff = eff_hbits(hbits_r);

  lhbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .hold      (bk_stat.clearing),
    .n_eff     (n_eff),
    .q_push    (q_push),
    .q_item    (q_item),
    .q_full    (q_full)
  );

  lhbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  lhbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .hb_eff     (hb_eff),
    .stat       (bk_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  assign out_ent = out_tdata[ENT_W-1:0];

  `LHBP_ASSERT_NEVER(a_no_accept_in_clear, in_tready && bk_stat.clearing)
  `LHBP_ASSERT_NEVER(a_no_queue_overflow, q_push && q_full)
  `LHBP_ASSERT_NEVER(a_no_lookup_in_clear, bk_stat.busy && bk_stat.clearing)
  `LHBP_ASSERT_IMPLY(a_miss_counted, out_tvalid && out_tdata[13], out_tdata[45:14] != 32'd0)
  `LHBP_ASSERT_IMPLY(a_entry_in_range, out_tvalid, NCFG_W'(out_ent) < n_eff)

endmodule

// ----- tb/tb_local_history_branch_predictor_unit.sv -----
`timescale 1ns / 1ps

// Branch predictor testbench: a table of directed rows, then random phases.
// Each phase writes both registers while the block is drained, then streams
// resolved branches. Most branches come from a small pool of looping branches
// with periodic outcomes, so the counters and histories train; the rest are
// noise. Each word is checked against a shadow predictor or a hand-worked row.
module tb_local_history_branch_predictor_unit;
  import lhbp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYC    = 80;    // long receiver hold-off
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 73;
  localparam int MAX_LINES   = 40;    // mismatch lines printed, all are counted

  // register indexes the block has no register for
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAST   = 8'hFF;

  typedef enum logic {ROW_BRANCH, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic [15:0]           pc;
    logic                  tk;
    logic                  known;   // want holds a hand-worked result
    res_t                  want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;    // branch_index[15:0], taken[16], pad
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;   // entry, history, pred, miss flag, count, pad
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  local_history_branch_predictor_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow predictor state: registers as written (raw), tables as in the block
  // ---------------------------------------------------------------------------
  logic [NCFG_W-1:0]  n_entries_reg;
  logic [HBCFG_W-1:0] hist_len_reg;
  logic [7:0]         local_hist   [ENTRIES_MAX];
  logic [1:0]         pattern_ctr  [CTR_DEPTH];
  logic [MISS_W-1:0]  entry_misses [ENTRIES_MAX];

  res_t     verdict_q [$];   // predicted words, oldest first
  dir_row_t dir_tab   [$];

  int   err_count;
  int   burst_left;          // words left in the current sender burst
  logic gaps_on;             // sender idles between bursts
  logic hold_req;            // ask the receiver for one long hold-off
  int   rx_mode;
  int   rx_tick;
  int   cyc;
  res_t mon_got;
  res_t mon_want;

  // One resolved branch through the shadow tables; returns the word the block
  // should send and leaves the tables updated.
  function automatic res_t resolve_branch(input logic [15:0] pc, input logic tk);
    int         n;
    int         hb;
    int         ent;
    int         slot;
    logic [7:0] hsel;
    logic [1:0] c;
    res_t       r;
    // zero means one; anything past the table size clamps to it
    if (n_entries_reg == 0) n = 1;
    else if (n_entries_reg > ENTRIES_MAX) n = ENTRIES_MAX;
    else n = n_entries_reg;
    if (hist_len_reg == 0) hb = 1;
    else if (hist_len_reg > HIST_MAX) hb = HIST_MAX;
    else hb = hist_len_reg;
    ent  = pc % n;
    hsel = local_hist[ent] & 8'((1 << hb) - 1);
    slot = (ent << HIST_MAX) + hsel;
    c    = pattern_ctr[slot];
    r.entry_index     = ENT_W'(ent);
    r.history_used    = hsel;
    r.predicted_taken = (c == CTR_WT) || (c == CTR_ST);
    r.mispredicted    = (r.predicted_taken != tk);
    // two-bit counter, saturating at both ends
    if (tk && c != CTR_ST) c = c + 2'd1;
    else if (!tk && c != CTR_SN) c = c - 2'd1;
    pattern_ctr[slot] = c;
    // count saturates at all ones; out of reach in a run of this length
    if (r.mispredicted && entry_misses[ent] != '1) entry_misses[ent] = entry_misses[ent] + 1;
    r.miss_count = entry_misses[ent];
    // full 8-bit history kept, whatever the configured length
    local_hist[ent] = {local_hist[ent][6:0], tk};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r          = '0;
    r.kind     = ROW_CFG;
    r.reg_idx  = idx;
    r.reg_data = val;
    return r;
  endfunction

  function automatic dir_row_t br_row(input logic [15:0] pc, input logic tk);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_BRANCH;
    r.pc   = pc;
    r.tk   = tk;
    return r;
  endfunction

  function automatic dir_row_t known_row(input logic [15:0] pc, input logic tk,
                                         input logic [ENT_W-1:0] ent,
                                         input logic [7:0] hist, input logic pred,
                                         input logic miss, input logic [31:0] cnt);
    dir_row_t r;
    r       = br_row(pc, tk);
    r.known = 1'b1;
    r.want  = '{cnt, miss, pred, hist, ent};
    return r;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input dir_row_t r);
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MAX_LINES)
      $display("MISMATCH @%0t %s: got %0h want %0h", $realtime, what, got, want);
    err_count++;
  endtask

  // Offer one branch word, honoring the burst/gap pattern. Valid is raised at
  // a falling edge and left high when the next word follows straight on.
  task automatic send_branch(input logic [15:0] pc, input logic tk,
                             input logic known, input res_t typed);
    int   gap;
    res_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end else begin
        @(negedge clk);
      end
    end else begin
      @(negedge clk);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({tk, pc});
    do @(posedge clk); while (!in_tready);
    r = resolve_branch(pc, tk);
    verdict_q.insert(verdict_q.size(), known ? typed : r);
  endtask

  // Stop sending and wait for every outstanding word; the block is then idle,
  // since each branch makes exactly one word.
  task automatic drain_results;
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    // only the low register bits are kept; other indexes are dropped
    if (idx == REG_ENTRIES) n_entries_reg = val[NCFG_W-1:0];
    else if (idx == REG_HIST) hist_len_reg = val[HBCFG_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Generous: covers the post-reset RAM clear plus every word waiting out the
  // worst gaps and stalls several times over.
  initial begin
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("local_history_branch_predictor_unit test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern redrawn whenever rx_tick runs out; one long hold on request
  // ---------------------------------------------------------------------------
  always begin
    @(negedge clk);
    if (hold_req) begin
      out_tready <= 1'b0;
      repeat (HOLD_CYC) @(negedge clk);
      hold_req = 1'b0;
    end else begin
      if (rx_tick == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_tick = 64;
      end
      rx_tick--;
      case (rx_mode)
        0:       out_tready <= 1'b1;                        // no stalls
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 3) == 0);  // heavy stalls
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      mon_got = res_t'(out_tdata[RES_W-1:0]);
      if (out_tdata[OUT_W-1:RES_W] != '0)
        report_mismatch("pad bits", 32'(out_tdata[OUT_W-1:RES_W]), 32'd0);
      if (verdict_q.size() == 0) begin
        report_mismatch("word with none pending", 32'(mon_got.entry_index), 32'd0);
      end else begin
        mon_want = verdict_q.pop_front();
        if (mon_got.entry_index != mon_want.entry_index)
          report_mismatch("entry_index", 32'(mon_got.entry_index),
                          32'(mon_want.entry_index));
        if (mon_got.history_used != mon_want.history_used)
          report_mismatch("history_used", 32'(mon_got.history_used),
                          32'(mon_want.history_used));
        if (mon_got.predicted_taken != mon_want.predicted_taken)
          report_mismatch("predicted_taken", 32'(mon_got.predicted_taken),
                          32'(mon_want.predicted_taken));
        if (mon_got.mispredicted != mon_want.mispredicted)
          report_mismatch("mispredicted", 32'(mon_got.mispredicted),
                          32'(mon_want.mispredicted));
        if (mon_got.miss_count != mon_want.miss_count)
          report_mismatch("miss_count", mon_got.miss_count, mon_want.miss_count);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int                    ph;
    int                    k;
    int                    sel;
    int                    ent_val;
    int                    hb_val;
    logic [CFG_DATA_W-1:0] wdata;
    logic [15:0]           pc;
    logic                  tk;
    logic [15:0]           pool_pc  [4];
    logic [7:0]            pool_pat [4];
    int                    pool_len [4];
    int                    pool_pos [4];
    dir_row_t              row;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    err_count  = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    hold_req   = 1'b0;
    rx_mode    = 0;
    rx_tick    = 0;

    n_entries_reg = ENTRIES_RST;
    hist_len_reg  = HIST_RST;
    foreach (local_hist[i]) local_hist[i] = '0;
    foreach (entry_misses[i]) entry_misses[i] = '0;
    foreach (pattern_ctr[i]) pattern_ctr[i] = CTR_SN;

    // Directed rows. Reset state: one entry, two history bits, all clear.
    add_row(known_row(16'h0000, 1'b0, 4'd0, 8'h00, 1'b0, 1'b0, 32'd0));
    add_row(known_row(16'hFFFF, 1'b1, 4'd0, 8'h00, 1'b0, 1'b1, 32'd1));
    // widest settings
    add_row(cfg_row(REG_ENTRIES, 8'd16));
    add_row(cfg_row(REG_HIST, 8'd8));
    add_row(known_row(16'hFFFF, 1'b1, 4'd15, 8'h00, 1'b0, 1'b1, 32'd1));
    add_row(known_row(16'h000F, 1'b0, 4'd15, 8'h01, 1'b0, 1'b0, 32'd1));
    // zero in both registers (high data bits set, dropped): one entry, one bit
    add_row(cfg_row(REG_ENTRIES, 8'hE0));
    add_row(cfg_row(REG_HIST, 8'hF0));
    // train entry 0 up to strongly taken and past it, then a taken-side miss
    add_row(br_row(16'h1234, 1'b1));
    add_row(br_row(16'h0000, 1'b1));
    add_row(br_row(16'h0000, 1'b1));
    add_row(br_row(16'h0000, 1'b1));
    add_row(br_row(16'h0000, 1'b0));
    // writes to indexes with no register
    add_row(cfg_row(REG_UNUSED, 8'h05));
    add_row(cfg_row(REG_LAST, 8'hFF));
    add_row(br_row(16'h0000, 1'b0));
    // over-range values clamp to 16 entries, 8 bits; stored history shows in full
    add_row(cfg_row(REG_ENTRIES, 8'h3F));
    add_row(cfg_row(REG_HIST, 8'h0F));
    add_row(br_row(16'h0010, 1'b1));
    add_row(br_row(16'hAAAA, 1'b1));
    add_row(br_row(16'h5555, 1'b0));
    // a count that does not divide the index space
    add_row(cfg_row(REG_ENTRIES, 8'h0D));
    add_row(cfg_row(REG_HIST, 8'h05));
    add_row(br_row(16'hFFFF, 1'b0));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.kind == ROW_CFG) begin
        drain_results();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        send_branch(row.pc, row.tk, row.known, row.want);
      end
    end

    // Random phases: new settings, a fresh pool of looping branches.
    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      if (ph == 0) begin
        ent_val = ENTRIES_MAX;
        hb_val  = HIST_MAX;
      end else if (ph == 1) begin
        ent_val = 1;
        hb_val  = 1;
      end else begin
        case ($urandom_range(0, 4))
          0:       ent_val = 0;
          1:       ent_val = 1;
          2:       ent_val = ENTRIES_MAX;
          3:       ent_val = $urandom_range(ENTRIES_MAX + 1, 31);
          default: ent_val = $urandom_range(2, ENTRIES_MAX - 1);
        endcase
        case ($urandom_range(0, 4))
          0:       hb_val = 0;
          1:       hb_val = 1;
          2:       hb_val = HIST_MAX;
          3:       hb_val = $urandom_range(HIST_MAX + 1, 15);
          default: hb_val = $urandom_range(2, HIST_MAX - 1);
        endcase
      end
      // random junk in the bits above each register
      wdata = (8'($urandom) & 8'hE0) | 8'(ent_val);
      write_reg(REG_ENTRIES, wdata);
      wdata = (8'($urandom) & 8'hF0) | 8'(hb_val);
      write_reg(REG_HIST, wdata);
      if ($urandom_range(0, 2) == 0)
        write_reg(8'($urandom_range(REG_UNUSED, REG_LAST)), 8'($urandom));

      for (k = 0; k < 4; k++) begin
        pool_pc[k]  = 16'($urandom);
        pool_pat[k] = 8'($urandom);
        pool_len[k] = $urandom_range(1, 8);
        pool_pos[k] = 0;
      end

      gaps_on = ($urandom_range(0, 3) != 0);
      // back-pressure phase: receiver stops, sender keeps pushing until the
      // input stalls
      if (ph == 3) begin
        gaps_on  = 1'b0;
        hold_req = 1'b1;
      end

      for (k = 0; k < PHASE_ITEMS; k++) begin
        // mid-phase pause until every pending word is back
        if (ph == 5 && k == PHASE_ITEMS / 2) drain_results();
        if ($urandom_range(0, 3) != 0) begin
          sel = $urandom_range(0, 3);
          pc  = pool_pc[sel];
          tk  = pool_pat[sel][pool_pos[sel]];
          pool_pos[sel] = (pool_pos[sel] + 1) % pool_len[sel];
        end else begin
          case ($urandom_range(0, 3))
            0:       pc = 16'h0000;
            1:       pc = 16'hFFFF;
            default: pc = 16'($urandom);
          endcase
          tk = 1'($urandom_range(0, 1));
        end
        send_branch(pc, tk, 1'b0, '0);
      end
    end

    drain_results();
    // catch any stray word after the last expected one
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("local_history_branch_predictor_unit test passed");
    end else begin
      $display("local_history_branch_predictor_unit test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/lhbp_pkg.sv
hw/rtl/lhbp_ram.sv
hw/rtl/lhbp_front.sv
hw/rtl/lhbp_queue.sv
hw/rtl/lhbp_back.sv
hw/rtl/local_history_branch_predictor_unit.sv
tb/tb_local_history_branch_predictor_unit.sv
